[sv/fhs_pkg.sv]
// ----------------------------------------------------------------------------
// fhs_pkg
// Shared types, bit matrices and address tables of the flash halfword
// scrambler.
// ----------------------------------------------------------------------------
package fhs_pkg;

  // Configuration port sizes and register indexes.
  localparam int CFG_INDEX_WIDTH = 8;
  localparam int CFG_DATA_WIDTH  = 25;
  localparam int REGION_WIDTH    = 25;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BASE_CODE    = 8'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_REGION_START = 8'd1;

  localparam logic [REGION_WIDTH-1:0] REGION_START_RESET = 25'h1000084;

  // Address bits that feed the address terms: bits 1 to 24, plus bit 0 of
  // the masks (always clear in the table).
  localparam int TERM_ADDR_WIDTH = 25;
  localparam int N_ADDR_BITS     = 24;
  localparam int N_ADDR_MASKS    = 25;

  // A 16x16 GF(2) matrix stored as 16 columns; element i is column i.
  typedef logic [15:0][15:0] mat_t;
  typedef logic [N_ADDR_BITS-1:0][15:0] addr_term_tab_t;
  typedef logic [N_ADDR_MASKS-1:0][TERM_ADDR_WIDTH-1:0] mask_bit_tab_t;
  typedef logic [N_ADDR_MASKS-1:0][15:0] mask_term_tab_t;

  // Forward scrambling matrix, column 15 first.
  localparam mat_t MAT_FWD = {
    16'hA908, 16'h5221, 16'h2908, 16'h1000, 16'h0900, 16'hAD1A, 16'h1220, 16'h0100,
    16'h52A1, 16'hFFFF, 16'h1020, 16'hA918, 16'h0908, 16'h52A5, 16'hA91A, 16'h1221
  };

  // Term for address bit k+1, entry 23 first.
  localparam addr_term_tab_t ADDR_TERM = {
    16'hEFDF, 16'h0000, 16'hA818, 16'h5B21, 16'hB93A, 16'h56E7, 16'hA91A, 16'h4084,
    16'h5221, 16'h8432, 16'h0000, 16'hEE9F, 16'h5080, 16'hDFF7, 16'hEFDF, 16'h4285,
    16'hCBB1, 16'h52A5, 16'h14C4, 16'hA71B, 16'hD6F7, 16'hC99F, 16'h3E7F, 16'h0FAE
  };

  // Address bit masks, entry 24 first; a term applies when all mask bits are set.
  localparam mask_bit_tab_t MASK_BITS = {
    25'h800000, 25'h080100, 25'h044000, 25'h040040, 25'h020200,
    25'h010400, 25'h010040, 25'h010010, 25'h00A000, 25'h009000,
    25'h008008, 25'h004040, 25'h004010, 25'h002080, 25'h002020,
    25'h001100, 25'h001080, 25'h001020, 25'h000900, 25'h000840,
    25'h000810, 25'h000600, 25'h000480, 25'h000220, 25'h000140
  };

  localparam mask_term_tab_t MASK_TERM = {
    16'hB908, 16'hA918, 16'h1B20, 16'hA91A, 16'h53A5,
    16'h0908, 16'h5221, 16'hAD1A, 16'hBD3A, 16'h1000,
    16'h2908, 16'hA908, 16'hA91A, 16'hFBBD, 16'h0100,
    16'h52A1, 16'h0908, 16'h1221, 16'h2008, 16'h1220,
    16'h5221, 16'hB928, 16'h1221, 16'h52A1, 16'h1000
  };

  // Matrix times vector over GF(2): XOR of the columns selected by x.
  function automatic logic [15:0] gf2_mul(mat_t m, logic [15:0] x);
    logic [15:0] y;
    y = '0;
    for (int i = 0; i < 16; i++) begin
      if (x[i]) begin
        y = y ^ m[i];
      end
    end
    return y;
  endfunction

  // Gauss-Jordan elimination on the columns; the returned columns solve
  // m * x = y as the XOR of the columns selected by y. Used at elaboration.
  function automatic mat_t gf2_inverse(mat_t m);
    mat_t        v;
    mat_t        c;
    int          p;
    logic [15:0] tv;
    logic [15:0] tc;
    for (int j = 0; j < 16; j++) begin
      v[j] = m[j];
      c[j] = 16'(1) << j;
    end
    for (int b = 0; b < 16; b++) begin
      // Lowest column at or after b with bit b set is the pivot.
      p = 16;
      for (int j = 15; j >= b; j--) begin
        if (v[j][b]) begin
          p = j;
        end
      end
      if (p != 16) begin
        if (p != b) begin
          tv   = v[p];
          tc   = c[p];
          v[p] = v[b];
          c[p] = c[b];
          v[b] = tv;
          c[b] = tc;
        end
        for (int k = 0; k < 16; k++) begin
          if (k != b && v[k][b]) begin
            v[k] = v[k] ^ v[b];
            c[k] = c[k] ^ c[b];
          end
        end
      end
    end
    return c;
  endfunction

  localparam mat_t MAT_INV = gf2_inverse(MAT_FWD);

endpackage

[sv/fhs_addr_terms.sv]
// ----------------------------------------------------------------------------
// fhs_addr_terms
// Combines the per-bit and per-mask address constants of one halfword
// address into its 16-bit address term.
// ----------------------------------------------------------------------------
module fhs_addr_terms (
  input  logic [fhs_pkg::TERM_ADDR_WIDTH-1:0] addr,
  output logic [15:0]                         terms
);
  import fhs_pkg::*;

  logic [15:0] bit_terms;
  logic [15:0] mask_terms;

  // One constant for each set address bit from bit 1 up.
  always_comb begin
    bit_terms = '0;
    for (int i = 0; i < N_ADDR_BITS; i++) begin
      if (addr[i+1]) begin
        bit_terms = bit_terms ^ ADDR_TERM[i];
      end
    end
  end

  // One constant for each mask whose bits are all set.
  always_comb begin
    mask_terms = '0;
    for (int i = 0; i < N_ADDR_MASKS; i++) begin
      if ((addr & MASK_BITS[i]) == MASK_BITS[i]) begin
        mask_terms = mask_terms ^ MASK_TERM[i];
      end
    end
  end

  assign terms = bit_terms ^ mask_terms;

endmodule

[sv/flash_halfword_scrambler.sv]
// ----------------------------------------------------------------------------
// flash_halfword_scrambler
// Encrypts or decrypts flash halfwords by base code, bit matrix and address
// terms; halfwords below the scrambled region pass through.
// ----------------------------------------------------------------------------
// The block takes one halfword beat per clock and presents the results on
// the output in order. Each beat passes through four register stages
// (input capture, address terms and region test, matrix, final XOR and
// output); a stall on the output side holds every stage and lets bubbles
// close up, so throughput stays at one beat per cycle whenever the output
// side is ready. Configuration writes take effect at once and are meant
// to be made while no beat is in flight.
module flash_halfword_scrambler #(
  parameter int ADDRESS_WIDTH = 25
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration write channel.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [fhs_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [fhs_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
  // Input stream.
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // s_tdata: byte_address, halfword_in, zero fill.
  input  logic [((ADDRESS_WIDTH+16+7)/8)*8-1:0] s_tdata,
  // s_tuser: kind (0 encrypt, 1 decrypt).
  input  logic                                 s_tuser,
  // Output stream.
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // m_tdata: halfword_out.
  output logic [15:0]                          m_tdata,
  // m_tuser: was_scrambled.
  output logic                                 m_tuser
);
  import fhs_pkg::*;

  localparam int AW = ADDRESS_WIDTH;

  // Configuration registers.
  logic [15:0]             base_code;
  logic [REGION_WIDTH-1:0] region_start;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_code    <= '0;
      region_start <= REGION_START_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_BASE_CODE) begin
        base_code <= cfg_data[15:0];
      end else if (cfg_index == REG_REGION_START) begin
        region_start <= cfg_data[REGION_WIDTH-1:0];
      end
    end
  end

  // Stage valids and the ready chain; a stage moves when it is empty or
  // the stage after it moves.
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4     = !v4 || m_tready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= s_tvalid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy4) begin
        v4 <= v3;
      end
    end
  end

  // Stage 1: capture the input beat.
  logic          kind1;
  logic [AW-1:0] addr1;
  logic [15:0]   data1;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      kind1 <= s_tuser;
      addr1 <= s_tdata[AW-1:0];
      data1 <= s_tdata[AW+15:AW];
    end
  end

  // Stage 2: region test and address terms.
  logic [15:0] terms1;
  logic        in_region1;
  logic        kind2;
  logic        in_region2;
  logic [15:0] terms2;
  logic [15:0] data2;

  fhs_addr_terms u_addr_terms (
    .addr  (addr1[TERM_ADDR_WIDTH-1:0]),
    .terms (terms1)
  );

  assign in_region1 = {addr1[AW-1:1], 1'b0} >= AW'(region_start);

  always_ff @(posedge clk) begin
    if (rdy2) begin
      kind2      <= kind1;
      in_region2 <= in_region1;
      terms2     <= terms1;
      data2      <= data1;
    end
  end

  // Stage 3: pre-whitening and the forward or inverse matrix.
  logic [15:0] pre2;
  logic [15:0] mixed2;
  logic        kind3;
  logic        in_region3;
  logic [15:0] terms3;
  logic [15:0] data3;
  logic [15:0] mixed3;

  assign pre2   = kind2 ? (data2 ^ terms2) : (data2 ^ base_code);
  assign mixed2 = kind2 ? gf2_mul(MAT_INV, pre2) : gf2_mul(MAT_FWD, pre2);

  always_ff @(posedge clk) begin
    if (rdy3) begin
      kind3      <= kind2;
      in_region3 <= in_region2;
      terms3     <= terms2;
      data3      <= data2;
      mixed3     <= mixed2;
    end
  end

  // Stage 4: post-whitening and pass-through select into the output register.
  logic [15:0] post3;
  logic [15:0] result4;
  logic        scrambled4;

  assign post3 = kind3 ? (mixed3 ^ base_code) : (mixed3 ^ terms3);

  always_ff @(posedge clk) begin
    if (rdy4) begin
      result4    <= in_region3 ? post3 : data3;
      scrambled4 <= in_region3;
    end
  end

  assign m_tvalid = v4;
  assign m_tdata  = result4;
  assign m_tuser  = scrambled4;

  // A stalled output stage keeps its beat.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (v4 && !m_tready) |=> (v4 && $stable(result4) && $stable(scrambled4)))
    else $error("output stage changed while stalled");

  // A middle stage blocked from below keeps its beat.
  a_mid_hold: assert property (@(posedge clk) disable iff (rst)
    (v3 && !rdy4) |=> (v3 && $stable(mixed3) && $stable(in_region3)))
    else $error("matrix stage changed while blocked");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!m_tvalid && !v1 && !v2 && !v3))
    else $error("pipeline not empty after reset");

endmodule
